### design/mf3_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3_pkg: shared types, constants and helpers of the 3x3 median filter
// Frame limits, register indexes and the compare networks used to find the
// median of a 3x3 window.
// ---------------------------------------------------------------------------
package mf3_pkg;

  // Frame limits and field widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_MIN    = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;

  // Configuration register indexes
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Reset value of both dimension registers
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

  typedef logic [PIX_W-1:0] pix_t;

  // Three values in ascending order
  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } tri_sort_t;

  // Last valid index for a dimension: value clamped to [DIM_MIN, max_dim], minus one
  function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] clamped;
    if (v < DIM_W'(DIM_MIN)) begin
      clamped = DIM_W'(DIM_MIN);
    end else if (v > max_dim) begin
      clamped = max_dim;
    end else begin
      clamped = v;
    end
    return clamped - DIM_W'(1);
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  // Three-element sort network (three compare-exchange steps)
  function automatic tri_sort_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t l0;
    pix_t h0;
    pix_t l1;
    pix_t h1;
    tri_sort_t s;
    l0    = min2(a, b);
    h0    = max2(a, b);
    h1    = max2(h0, c);
    l1    = min2(h0, c);
    s.lo  = min2(l0, l1);
    s.mid = max2(l0, l1);
    s.hi  = h1;
    return s;
  endfunction

  // Median of nine: sort rows, then median of (max of lows, median of mids,
  // min of highs)
  function automatic pix_t median9(input pix_t p0, input pix_t p1, input pix_t p2,
                                   input pix_t p3, input pix_t p4, input pix_t p5,
                                   input pix_t p6, input pix_t p7, input pix_t p8);
    tri_sort_t r0;
    tri_sort_t r1;
    tri_sort_t r2;
    tri_sort_t lows;
    tri_sort_t mids;
    tri_sort_t highs;
    tri_sort_t fin;
    r0    = sort3(p0, p1, p2);
    r1    = sort3(p3, p4, p5);
    r2    = sort3(p6, p7, p8);
    lows  = sort3(r0.lo, r1.lo, r2.lo);
    mids  = sort3(r0.mid, r1.mid, r2.mid);
    highs = sort3(r0.hi, r1.hi, r2.hi);
    fin   = sort3(lows.hi, mids.mid, highs.lo);
    return fin.mid;
  endfunction

endpackage

### design/median_filter_3x3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter for 8-bit grayscale frames
// Two line stores and a 3x3 window; one median per interior pixel.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/in_pixel_in, one
//   transaction per pixel. For every pixel at row >= 2, col >= 2 the median
//   of the window centred one row up and one column left leaves on
//   out_valid/out_stall with out_median_out; out_frame_last marks the last
//   interior result of a frame. Border positions give no result.
//   Throughput is one pixel per clock while the output is not stalled. The
//   accepted pixel and its line store reads are registered in stage 1, then
//   the window (stage 2), then the output register, which drives the result.
//   The three stages each hold one transaction, so a stalled result does not
//   block input until the stages behind it fill; in_stall rises only while
//   out_stall holds a full pipeline.
//   frame_width / frame_height (cfg index 0 / 1) are clamped to 3..1024; the
//   user must write them only while the block is idle (the block does not enforce it).
//   Synchronous reset clears counters, window, pipeline valids and sets both
//   dimensions to 1024. Line stores are not cleared; the first two rows of a
//   frame fill them before they are read.
// ---------------------------------------------------------------------------
module median_filter_3x3 (
  input  logic                             clk,
  input  logic                             rst_n,
  // input pixel channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mf3_pkg::PIX_W-1:0]        in_pixel_in,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mf3_pkg::PIX_W-1:0]        out_median_out,
  output logic                             out_frame_last,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [mf3_pkg::IDX_W-1:0]        cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]        cfg_data
);

  // configuration
  logic [mf3_pkg::DIM_W-1:0] frame_width_r;
  logic [mf3_pkg::DIM_W-1:0] frame_height_r;

  // position counters
  logic [mf3_pkg::COL_W-1:0] col_r;
  logic [mf3_pkg::COL_W-1:0] col_nxt;
  logic [mf3_pkg::ROW_W-1:0] row_r;
  logic [mf3_pkg::ROW_W-1:0] row_nxt;
  logic [mf3_pkg::DIM_W-1:0] w_last_full;
  logic [mf3_pkg::DIM_W-1:0] h_last_full;
  logic [mf3_pkg::COL_W-1:0] w_last;
  logic [mf3_pkg::ROW_W-1:0] h_last;
  logic                      row_end;
  logic                      frame_end;
  logic                      emit;

  // line stores
  mf3_pkg::pix_t line_older [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t line_newer [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t top_rd_r;
  mf3_pkg::pix_t mid_rd_r;

  // stage 1: accepted pixel awaiting window update
  logic                      s1_valid_r;
  mf3_pkg::pix_t             s1_px_r;
  logic [mf3_pkg::COL_W-1:0] s1_col_r;
  logic                      s1_emit_r;
  logic                      s1_last_r;

  // stage 2: window holding an interior neighbourhood
  mf3_pkg::pix_t win_r [3][3];
  logic          s2_valid_r;
  logic          s2_last_r;
  mf3_pkg::pix_t median;

  // output register
  logic          out_valid_r;
  mf3_pkg::pix_t out_median_r;
  logic          out_last_r;

  // handshake
  logic in_accept;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic s1_move;
  logic s2_move;

  // Pipeline flow: each stage moves when the one after it is free
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_move   = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_move   = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mf3_pkg::DIM_RESET;
      frame_height_r <= mf3_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mf3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        mf3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective last column / row and position decode
  always_comb begin
    w_last_full = mf3_pkg::last_index(frame_width_r, mf3_pkg::DIM_W'(mf3_pkg::MAX_WIDTH));
    h_last_full = mf3_pkg::last_index(frame_height_r, mf3_pkg::DIM_W'(mf3_pkg::MAX_HEIGHT));
    w_last      = w_last_full[mf3_pkg::COL_W-1:0];
    h_last      = h_last_full[mf3_pkg::ROW_W-1:0];
    row_end     = (col_r >= w_last);
    frame_end   = row_end && (row_r >= h_last);
    emit        = (row_r >= mf3_pkg::ROW_W'(2)) && (col_r >= mf3_pkg::COL_W'(2));
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_last) ? '0 : row_r + mf3_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_r + mf3_pkg::COL_W'(1);
      row_nxt = row_r;
    end
  end

  // Counters advance per accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store read at accept, write back when stage 1 moves on
  always_ff @(posedge clk) begin
    if (in_accept) begin
      top_rd_r <= line_older[col_r];
      mid_rd_r <= line_newer[col_r];
    end
    if (s1_move) begin
      line_older[s1_col_r] <= mid_rd_r;
      line_newer[s1_col_r] <= s1_px_r;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r   <= in_pixel_in;
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= frame_end;
    end
  end

  // Window shift: new column enters on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (s1_move) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top_rd_r;
      win_r[1][2] <= mid_rd_r;
      win_r[2][2] <= s1_px_r;
    end
  end

  // Stage 2 control: window valid only for interior positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= s1_emit_r;
      s2_last_r  <= s1_last_r;
    end else if (s2_move) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Median network
  assign median = mf3_pkg::median9(win_r[0][0], win_r[0][1], win_r[0][2],
                                   win_r[1][0], win_r[1][1], win_r[1][2],
                                   win_r[2][0], win_r[2][1], win_r[2][2]);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_move) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_median_r <= median;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median_out = out_median_r;
  assign out_frame_last = out_last_r;

endmodule

### design/mf3_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mf3_checker: port-level checks for the 3x3 median filter
// Watches the channel handshakes of the top level and is bound to it.
// ---------------------------------------------------------------------------
module mf3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mf3_pkg::PIX_W-1:0] out_median_out,
  input logic                      out_frame_last
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_out) && $stable(out_frame_last))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input is only held off by a stalled, pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // With the output empty, the pipeline always has room
  a_room_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_median_out (out_median_out),
  .out_frame_last (out_frame_last)
);
